>>> sv/cswr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cswr_pkg: shared constants for the clock synthesizer register writer
// field widths, command and status codes, device register map
// ----------------------------------------------------------------------------
package cswr_pkg;

  // field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned IntW    = 10;
  localparam int unsigned FracW   = 20;
  localparam int unsigned RdivW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LoadW   = 2;

  // divider: 128*b is a 27-bit dividend
  localparam int unsigned DividendW = FracW + 7;
  localparam int unsigned P1W       = 18;

  localparam int unsigned OutputCountDef = 3;
  localparam logic [LoadW-1:0] LoadCodeRst = 2'd3;

  // command codes
  localparam logic [OpW-1:0] OP_SET_PLL  = 3'd0;
  localparam logic [OpW-1:0] OP_SET_DIV  = 3'd1;
  localparam logic [OpW-1:0] OP_SET_RDIV = 3'd2;
  localparam logic [OpW-1:0] OP_ENABLE   = 3'd3;
  localparam logic [OpW-1:0] OP_RESET    = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_READY = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [StatusW-1:0] ST_ZERO_DEN  = 2'd3;

  // device register map
  localparam logic [ByteW-1:0] REG_OUT_ENABLE = 8'd3;
  localparam logic [ByteW-1:0] REG_CLK_CTRL   = 8'd16;
  localparam logic [ByteW-1:0] REG_PLLA_BASE  = 8'd26;
  localparam logic [ByteW-1:0] REG_PLLB_BASE  = 8'd34;
  localparam logic [ByteW-1:0] REG_DIV_BASE   = 8'd42;
  localparam logic [ByteW-1:0] REG_RDIV_BASE  = 8'd44;
  localparam logic [ByteW-1:0] REG_PLL_RESET  = 8'd177;
  localparam logic [ByteW-1:0] REG_XTAL_LOAD  = 8'd183;

  // register values
  localparam logic [ByteW-1:0] PLL_RESET_VAL  = 8'hA0;
  localparam logic [ByteW-1:0] CLK_CTRL_BASE  = 8'h0F;
  localparam logic [ByteW-1:0] CLK_POWER_DOWN = 8'h80;
  localparam logic [ByteW-1:0] ALL_OFF        = 8'hFF;
  localparam logic [ByteW-1:0] ALL_ON         = 8'h00;

  // results per command, as the index of the final one
  localparam logic [3:0] LAST_PARAM = 4'd8;
  localparam logic [3:0] LAST_RESET = 4'd9;

endpackage
`default_nettype wire

>>> sv/clock_synth_register_writer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_synth_register_writer_unit: command to register write sequencer
// encodes pll and output divider ratios and emits device register writes
// ----------------------------------------------------------------------------
// One command is taken on the input channel and turned into a run of register
// writes (address, data) on the output channel, one write per transfer, with
// last marking the final one. A rejected command gives a single transfer with
// write_valid low and the status code. Set pll and set output divider encode
// a + b/c; with a nonzero numerator the floor of 128*b/c comes from a radix-2
// restoring divider that retires one quotient bit per cycle. Such a command
// is accepted, divides its 27-bit dividend, forms P1 and emits 9 writes.
// Integer mode skips the divider. Set r divider and enable give one write,
// reset mode ten, and a rejection one transfer. Commands 5 to 7 are taken
// and dropped. The input is not ready while a command is in work; the last
// write sits in the output register while the next command is taken. The
// crystal load code is written through cfg_we_i / cfg_wdata_i; the user
// must see that it is only changed while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module clock_synth_register_writer_unit #(
  parameter int unsigned OUTPUT_COUNT = cswr_pkg::OutputCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [cswr_pkg::LoadW-1:0]     cfg_wdata_i,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cswr_pkg::OpW-1:0]       operation_i,
  input  logic                           pll_select_i,
  input  logic [cswr_pkg::IdxW-1:0]      output_index_i,
  input  logic [cswr_pkg::IntW-1:0]      int_part_i,
  input  logic [cswr_pkg::FracW-1:0]     numerator_i,
  input  logic [cswr_pkg::FracW-1:0]     denominator_i,
  input  logic [cswr_pkg::RdivW-1:0]     rdiv_code_i,
  input  logic                           enable_outputs_i,
  // write channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           write_valid_o,
  output logic [cswr_pkg::ByteW-1:0]     reg_addr_o,
  output logic [cswr_pkg::ByteW-1:0]     reg_data_o,
  output logic [cswr_pkg::StatusW-1:0]   status_o,
  output logic                           last_o
);
  import cswr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SUM  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration and persistent state
  logic [LoadW-1:0] load_code_q;
  logic [1:0]       pll_ready_q;
  logic [ByteW-1:0] shadow_q [OUTPUT_COUNT];

  // captured command
  logic [OpW-1:0]     op_q;
  logic               pll_q;
  logic [IdxW-1:0]    idx_q;
  logic [IntW-1:0]    int_q;
  logic               frac_mode_q;
  logic [FracW-1:0]   den_q;
  logic               ena_q;
  logic [StatusW-1:0] status_q;

  // shared divider: remainder, dividend bits shifting out / quotient shifting in
  logic [FracW:0]       rem_q;
  logic [DividendW-1:0] quo_q;
  logic [4:0]           cnt_q;
  logic [P1W-1:0]       p1_q;

  // result sequencing
  logic [3:0] k_q;

  // output register
  logic             out_valid_q;
  logic             wv_q;
  logic [ByteW-1:0] addr_q;
  logic [ByteW-1:0] data_q;
  logic [StatusW-1:0] st_q;
  logic             last_q;

  // ---------------------------------------------------------------- accept
  logic             in_fire;
  logic             frac_nz;
  logic             zero_den;
  logic             idx_bad;
  logic [StatusW-1:0] chk_status;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign frac_nz    = (numerator_i != '0);
  assign zero_den   = frac_nz & (denominator_i == '0);
  assign idx_bad    = (output_index_i >= IdxW'(OUTPUT_COUNT));

  // rejection checks in priority order per command
  always_comb begin
    chk_status = ST_OK;
    case (operation_i)
      OP_SET_PLL: begin
        if (zero_den) chk_status = ST_ZERO_DEN;
      end
      OP_SET_DIV: begin
        if (!pll_ready_q[pll_select_i]) chk_status = ST_NOT_READY;
        else if (idx_bad)               chk_status = ST_BAD_INDEX;
        else if (zero_den)              chk_status = ST_ZERO_DEN;
      end
      OP_SET_RDIV: begin
        if (idx_bad) chk_status = ST_BAD_INDEX;
      end
      default: chk_status = ST_OK;
    endcase
  end

  // ---------------------------------------------------------------- divider
  // one restoring step: shift in the next dividend bit, try the subtract
  logic [FracW:0]   div_shift;
  logic [FracW+1:0] div_diff;
  logic             div_bit;

  assign div_shift = {rem_q[FracW-1:0], quo_q[DividendW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};
  assign div_bit   = ~div_diff[FracW+1];

  // P1 = 128*a + q - 512, kept to 18 bits
  logic [P1W-1:0] p1_sum;
  assign p1_sum = {1'b0, int_q, 7'b0} + quo_q[P1W-1:0] - P1W'(512);

  // ---------------------------------------------------------------- results
  logic [ByteW-1:0]   shadow_rd;
  logic [ByteW-1:0]   param_base;
  logic [ByteW-1:0]   param_byte;
  logic [ByteW-1:0]   ctl_byte;
  logic [FracW-1:0]   p2;
  logic [3:0]         last_k;
  logic               g_wv;
  logic [ByteW-1:0]   g_addr;
  logic [ByteW-1:0]   g_data;
  logic               g_last;

  assign p2 = rem_q[FracW-1:0];

  always_comb begin
    shadow_rd = '0;
    for (int i = 0; i < OUTPUT_COUNT; i++) begin
      if (idx_q == IdxW'(i)) shadow_rd = shadow_q[i];
    end
  end

  always_comb begin
    if (op_q == OP_SET_PLL) param_base = pll_q ? REG_PLLB_BASE : REG_PLLA_BASE;
    else                    param_base = REG_DIV_BASE + {2'b00, idx_q, 3'b000};
  end

  // packed parameter bytes: P3 high/low, P1, {P3[19:16], P2[19:16]}, P2
  always_comb begin
    case (k_q)
      4'd0:    param_byte = den_q[15:8];
      4'd1:    param_byte = den_q[7:0];
      4'd2:    param_byte = {6'b0, p1_q[17:16]};
      4'd3:    param_byte = p1_q[15:8];
      4'd4:    param_byte = p1_q[7:0];
      4'd5:    param_byte = {den_q[19:16], p2[19:16]};
      4'd6:    param_byte = p2[15:8];
      4'd7:    param_byte = p2[7:0];
      default: param_byte = '0;
    endcase
  end

  // clock control: pll b in bit 5, integer mode in bit 6
  assign ctl_byte = CLK_CTRL_BASE | {1'b0, ~frac_mode_q, pll_q, 5'b0};

  always_comb begin
    g_wv   = 1'b1;
    g_addr = '0;
    g_data = '0;
    last_k = '0;
    if (status_q != ST_OK) begin
      g_wv = 1'b0;
    end else begin
      case (op_q)
        OP_SET_PLL, OP_SET_DIV: begin
          last_k = LAST_PARAM;
          if (k_q == LAST_PARAM) begin
            if (op_q == OP_SET_PLL) begin
              g_addr = REG_PLL_RESET;
              g_data = PLL_RESET_VAL;
            end else begin
              g_addr = REG_CLK_CTRL + {5'b0, idx_q};
              g_data = ctl_byte;
            end
          end else begin
            g_addr = param_base + {4'b0, k_q};
            g_data = param_byte;
          end
        end
        OP_SET_RDIV: begin
          g_addr = REG_RDIV_BASE + {2'b00, idx_q, 3'b000};
          g_data = shadow_rd;
        end
        OP_ENABLE: begin
          g_addr = REG_OUT_ENABLE;
          g_data = ena_q ? ALL_ON : ALL_OFF;
        end
        OP_RESET: begin
          last_k = LAST_RESET;
          if (k_q == 4'd0) begin
            g_addr = REG_OUT_ENABLE;
            g_data = ALL_OFF;
          end else if (k_q == LAST_RESET) begin
            g_addr = REG_XTAL_LOAD;
            g_data = {load_code_q, 6'b0};
          end else begin
            g_addr = REG_CLK_CTRL + {4'b0, k_q} - 8'd1;
            g_data = CLK_POWER_DOWN;
          end
        end
        default: g_wv = 1'b0;
      endcase
    end
    g_last = (k_q == last_k);
  end

  // in the emit state, load the output register whenever it is free or being drained
  logic out_load;
  assign out_load = (state_q == S_EMIT) & (~out_valid_q | out_ready_i);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (chk_status != ST_OK) begin
            state_d = S_EMIT;
          end else begin
            case (operation_i)
              OP_SET_PLL, OP_SET_DIV: state_d = frac_nz ? S_DIV : S_SUM;
              OP_SET_RDIV, OP_ENABLE, OP_RESET: state_d = S_EMIT;
              default: state_d = S_IDLE;
            endcase
          end
        end
      end
      S_DIV: begin
        if (cnt_q == 5'(DividendW - 1)) state_d = S_SUM;
      end
      S_SUM:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_load && g_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_code_q <= LoadCodeRst;
      pll_ready_q <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < OUTPUT_COUNT; i++) shadow_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) load_code_q <= cfg_wdata_i;

      // persistent state changes on accepted commands
      if (in_fire && chk_status == ST_OK) begin
        case (operation_i)
          OP_SET_PLL: pll_ready_q[pll_select_i] <= 1'b1;
          OP_RESET:   pll_ready_q <= '0;
          OP_SET_RDIV: begin
            for (int i = 0; i < OUTPUT_COUNT; i++) begin
              if (output_index_i == IdxW'(i)) begin
                shadow_q[i] <= {1'b0, rdiv_code_i, shadow_q[i][3:0]};
              end
            end
          end
          default: ;
        endcase
      end

      // divider shadow byte is the top bits of P1
      if (state_q == S_SUM && op_q == OP_SET_DIV) begin
        for (int i = 0; i < OUTPUT_COUNT; i++) begin
          if (idx_q == IdxW'(i)) shadow_q[i] <= {6'b0, p1_sum[17:16]};
        end
      end

      if (in_fire) begin
        k_q   <= '0;
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (out_load) k_q <= k_q + 4'd1;

      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= operation_i;
      pll_q       <= pll_select_i;
      idx_q       <= output_index_i;
      int_q       <= int_part_i;
      frac_mode_q <= frac_nz;
      den_q       <= denominator_i;
      ena_q       <= enable_outputs_i;
      status_q    <= chk_status;
      rem_q       <= '0;
      quo_q       <= {numerator_i, 7'b0};
    end else if (state_q == S_DIV) begin
      rem_q <= div_bit ? div_diff[FracW:0] : div_shift;
      quo_q <= {quo_q[DividendW-2:0], div_bit};
    end
    if (state_q == S_SUM) p1_q <= p1_sum;
    if (out_load) begin
      wv_q   <= g_wv;
      addr_q <= g_addr;
      data_q <= g_data;
      st_q   <= status_q;
      last_q <= g_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign write_valid_o = wv_q;
  assign reg_addr_o    = addr_q;
  assign reg_data_o    = data_q;
  assign status_o      = st_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire
